// ===== rtl/si2b64_pkg.sv =====
package si2b64_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned SIG_W       = 64;
  localparam int unsigned EXP_W       = 12;
  localparam int unsigned LZC_W       = 6;
  localparam int unsigned SHIFT_W     = 13;

  // binary64 layout
  localparam int unsigned FRAC_BITS   = 52;
  localparam int unsigned EFIELD_W    = 11;
  localparam logic [EFIELD_W-1:0] EFIELD_MAX = 11'h7FF;

  // Shift and exponent adjustments (precision 53, minimum exponent -1074)
  localparam logic signed [SHIFT_W-1:0] NORM_ADJ  = 13'sd11;    // 64 - 53
  localparam logic signed [SHIFT_W-1:0] CLAMP_ADJ = 13'sd1074;  // -(minimum exponent)
  localparam logic signed [SHIFT_W-1:0] BIAS_ADJ  = 13'sd1086;  // 1075 + 11
  localparam logic signed [SHIFT_W-1:0] BIAS_OVF  = 13'sd2047;

  // Count leading zeros of a nonzero word; the highest set position is seen last and wins
  function automatic logic [LZC_W-1:0] lead_zeros(input logic [SIG_W-1:0] v);
    logic [LZC_W-1:0] lz;
    lz = '0;
    for (int i = 0; i < SIG_W; i++) begin
      if (v[i]) begin
        lz = LZC_W'(SIG_W - 1 - i);
      end
    end
    return lz;
  endfunction

endpackage

// ===== rtl/scaled_integer_to_binary64_core.sv =====
// An accepted transaction reaches the outputs through the input register and then
//   the result register. Throughput: one transaction per cycle while out_stall is low;
//   the two registers form a two-stage pipeline, and all packing logic sits between them.
// in_stall rises only when both stages are full and out_stall is high.
// Reset (rst, synchronous, active high) empties both stages; the data registers are not reset.
module scaled_integer_to_binary64_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             sign,
  input  logic signed [si2b64_pkg::EXP_W-1:0] exponent,
  input  logic [si2b64_pkg::SIG_W-1:0]     significand,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [si2b64_pkg::SIG_W-1:0]     double_bits,
  output logic                             digits_lost,
  output logic                             overflowed
);

  localparam int unsigned SW = si2b64_pkg::SHIFT_W;
  localparam int unsigned LW = si2b64_pkg::LZC_W;

  // Input stage
  logic                                 s1_valid;
  logic                                 sign_q;
  logic signed [si2b64_pkg::EXP_W-1:0]  exp_q;
  logic [si2b64_pkg::SIG_W-1:0]         sig_q;

  logic out_adv;
  logic s1_adv;

  // Advance the result stage whenever it is empty or being taken
  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = !s1_valid || out_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      sign_q <= sign;
      exp_q  <= exponent;
      sig_q  <= significand;
    end
  end

  // Packing logic
  logic [LW-1:0]                  lzc;
  logic signed [SW-1:0]           exp_ext;
  logic signed [SW-1:0]           shift_norm;
  logic signed [SW-1:0]           shift_clamp;
  logic                           normal;
  logic signed [SW-1:0]           shift_amt;
  logic signed [SW-1:0]           right_amt;
  logic                           right_far;
  logic [LW-1:0]                  right_sh;
  logic [si2b64_pkg::SIG_W-1:0]   low_mask;
  logic [si2b64_pkg::SIG_W-1:0]   sig_sh;
  logic                           lost;
  logic signed [SW-1:0]           biased;
  logic                           ovf;
  logic [si2b64_pkg::EFIELD_W-1:0] efield;
  logic [si2b64_pkg::SIG_W-1:0]   bits_next;
  logic                           lost_next;
  logic                           ovf_next;

  assign lzc         = si2b64_pkg::lead_zeros(sig_q);
  assign exp_ext     = {exp_q[si2b64_pkg::EXP_W-1], exp_q};
  assign shift_norm  = $signed({{(SW-LW){1'b0}}, lzc}) - si2b64_pkg::NORM_ADJ;
  assign shift_clamp = exp_ext + si2b64_pkg::CLAMP_ADJ;

  // Normalize unless that would push the exponent under the subnormal minimum
  assign normal    = shift_norm <= shift_clamp;
  assign shift_amt = normal ? shift_norm : shift_clamp;
  assign right_amt = -shift_amt;
  assign right_far = right_amt[SW-1:LW] != '0;
  assign right_sh  = right_amt[LW-1:0];
  assign low_mask  = ~({si2b64_pkg::SIG_W{1'b1}} << right_sh);

  always_comb begin
    if (!shift_amt[SW-1]) begin
      sig_sh = sig_q << shift_amt[LW-1:0];
      lost   = 1'b0;
    end else if (right_far) begin
      sig_sh = '0;
      lost   = 1'b1;
    end else begin
      sig_sh = sig_q >> right_sh;
      lost   = (sig_q & low_mask) != '0;
    end
  end

  assign biased = exp_ext - $signed({{(SW-LW){1'b0}}, lzc}) + si2b64_pkg::BIAS_ADJ;
  assign ovf    = normal && (biased >= si2b64_pkg::BIAS_OVF);
  assign efield = normal ? biased[si2b64_pkg::EFIELD_W-1:0] : '0;

  // Select zero, infinity or the packed encoding
  always_comb begin
    if (sig_q == '0) begin
      bits_next = {sign_q, {(si2b64_pkg::SIG_W-1){1'b0}}};
      lost_next = 1'b0;
      ovf_next  = 1'b0;
    end else if (ovf) begin
      bits_next = {sign_q, si2b64_pkg::EFIELD_MAX, {si2b64_pkg::FRAC_BITS{1'b0}}};
      lost_next = lost;
      ovf_next  = 1'b1;
    end else begin
      bits_next = {sign_q, efield, sig_sh[si2b64_pkg::FRAC_BITS-1:0]};
      lost_next = lost;
      ovf_next  = 1'b0;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      double_bits <= bits_next;
      digits_lost <= lost_next;
      overflowed  <= ovf_next;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction not held in the input stage");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> s1_valid)
    else $error("input stage dropped a transaction during a stall");

  a_ovf_is_inf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |->
      (double_bits[62:52] == si2b64_pkg::EFIELD_MAX && double_bits[51:0] == '0))
    else $error("overflow result is not an infinity");

endmodule

// ===== test/binary64_pack_checker.sv =====
`timescale 1ns / 100ps

// Watch both channels of the packer, predict each result and compare it
module binary64_pack_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                sign,
  input  logic signed [si2b64_pkg::EXP_W-1:0] exponent,
  input  logic [si2b64_pkg::SIG_W-1:0]        significand,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [si2b64_pkg::SIG_W-1:0]        double_bits,
  input  logic                                digits_lost,
  input  logic                                overflowed,
  output int                                  outstanding,
  output int                                  failures
);

  localparam int PRECISION  = 53;
  localparam int EXP_FLOOR  = -1074;
  localparam int BIAS_FLOOR = 1075;

  typedef struct packed {
    logic [si2b64_pkg::SIG_W-1:0] bits;
    logic                         lost;
    logic                         ovf;
  } binary64_result_t;

  binary64_result_t pending_doubles[$];

  // Pack (-1)^s * c * 2^e into binary64, truncating on right shifts
  function automatic binary64_result_t pack_binary64(
      input logic s,
      input logic signed [si2b64_pkg::EXP_W-1:0] e,
      input logic [si2b64_pkg::SIG_W-1:0] c);
    binary64_result_t r;
    int wid;
    int shift;
    int scale;
    int drop;
    int biased;
    logic [si2b64_pkg::SIG_W-1:0] cn;
    r.bits = {s, 63'd0};
    r.lost = 1'b0;
    r.ovf  = 1'b0;
    if (c == '0) begin
      return r;
    end
    wid = 0;
    for (int i = 0; i < si2b64_pkg::SIG_W; i++) begin
      if (c[i]) begin
        wid = i + 1;
      end
    end
    // Normalize to 53 bits, then clamp at the subnormal floor
    shift = PRECISION - wid;
    scale = e;
    scale = scale - shift;
    if (scale < EXP_FLOOR) begin
      shift = shift - (EXP_FLOOR - scale);
      scale = EXP_FLOOR;
    end
    if (shift >= 0) begin
      cn = c << shift;
    end else begin
      drop = -shift;
      if (drop >= si2b64_pkg::SIG_W) begin
        cn = '0;
        r.lost = 1'b1;
      end else begin
        cn = c >> drop;
        r.lost = |(c & ((64'd1 << drop) - 64'd1));
      end
    end
    // Only a full-width significand carries a nonzero biased exponent
    if (cn[si2b64_pkg::SIG_W-1:PRECISION] == '0 && cn[PRECISION-1]) begin
      biased = scale + BIAS_FLOOR;
    end else begin
      biased = 0;
    end
    if (biased >= int'(si2b64_pkg::EFIELD_MAX)) begin
      r.bits = {s, si2b64_pkg::EFIELD_MAX, {si2b64_pkg::FRAC_BITS{1'b0}}};
      r.ovf  = 1'b1;
    end else begin
      r.bits = {s, biased[si2b64_pkg::EFIELD_W-1:0], cn[si2b64_pkg::FRAC_BITS-1:0]};
    end
    return r;
  endfunction

  // Retire results against the oldest prediction, then queue new predictions
  always @(posedge clk) begin
    binary64_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_doubles.size() == 0) begin
          $display("%0t: unexpected transaction: double_bits %h digits_lost %b overflowed %b",
                   $time, double_bits, digits_lost, overflowed);
          failures++;
        end else begin
          want = pending_doubles.pop_front();
          if (double_bits !== want.bits) begin
            $display("%0t: double_bits expected %h actual %h", $time, want.bits, double_bits);
            failures++;
          end
          if (digits_lost !== want.lost) begin
            $display("%0t: digits_lost expected %b actual %b", $time, want.lost, digits_lost);
            failures++;
          end
          if (overflowed !== want.ovf) begin
            $display("%0t: overflowed expected %b actual %b", $time, want.ovf, overflowed);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_doubles.push_back(pack_binary64(sign, exponent, significand));
      end
      outstanding <= pending_doubles.size();
    end
  end

endmodule

// ===== test/tb_scaled_integer_to_binary64_core.sv =====
`timescale 1ns / 100ps

module tb_scaled_integer_to_binary64_core;

  localparam int RANDOM_ITEMS = 2000;

  // Idle modes for either side
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_FULL  = 1;
  localparam int IDLE_SHORT = 2;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic                                sign;
  logic signed [si2b64_pkg::EXP_W-1:0] exponent;
  logic [si2b64_pkg::SIG_W-1:0]        significand;
  logic                                out_valid;
  logic                                out_stall;
  logic [si2b64_pkg::SIG_W-1:0]        double_bits;
  logic                                digits_lost;
  logic                                overflowed;
  int                                  outstanding;
  int                                  failures;
  int                                  send_mode;

  scaled_integer_to_binary64_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sign        (sign),
    .exponent    (exponent),
    .significand (significand),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .double_bits (double_bits),
    .digits_lost (digits_lost),
    .overflowed  (overflowed)
  );

  binary64_pack_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sign        (sign),
    .exponent    (exponent),
    .significand (significand),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .double_bits (double_bits),
    .digits_lost (digits_lost),
    .overflowed  (overflowed),
    .outstanding (outstanding),
    .failures    (failures)
  );

  always #1 clk = ~clk;

  // Draw an idle count for the current mode: none, full range, or short
  function automatic int draw_idle(input int mode);
    if (mode == IDLE_NONE) begin
      return 0;
    end else if (mode == IDLE_FULL) begin
      return $urandom_range(0, 19);
    end
    return $urandom_range(0, 3);
  endfunction

  // Offer one operand after an idle gap and hold it until accepted
  task automatic send_operand(input logic s, input logic [si2b64_pkg::EXP_W-1:0] e,
                              input logic [si2b64_pkg::SIG_W-1:0] c);
    int gap;
    gap = draw_idle(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sign        <= s;
    exponent    <= e;
    significand <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Stimulus: directed corners first, then random operands
  initial begin
    int ev;
    int wid;
    logic [si2b64_pkg::SIG_W-1:0] c;
    logic [si2b64_pkg::SIG_W-1:0] mask;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    sign        <= 1'b0;
    exponent    <= '0;
    significand <= '0;
    send_mode   = IDLE_NONE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Signed zeros and the extreme exponents
    send_operand(1'b0, 12'd0, 64'd0);
    send_operand(1'b1, 12'h800, 64'd0);
    send_operand(1'b0, 12'h800, 64'd1);
    send_operand(1'b1, 12'h7FF, {si2b64_pkg::SIG_W{1'b1}});
    send_operand(1'b0, 12'h800, {si2b64_pkg::SIG_W{1'b1}});
    // Smallest subnormal, and one step below it
    send_operand(1'b0, -12'sd1074, 64'd1);
    send_operand(1'b1, -12'sd1075, 64'd1);
    // Largest subnormal and smallest normal
    send_operand(1'b0, -12'sd1074, (64'd1 << 52) - 64'd1);
    send_operand(1'b1, -12'sd1074, 64'd1 << 52);
    send_operand(1'b0, -12'sd1074, {si2b64_pkg::SIG_W{1'b1}});
    // Largest finite value and the first overflow beside it
    send_operand(1'b0, 12'sd971, (64'd1 << 53) - 64'd1);
    send_operand(1'b1, 12'sd972, (64'd1 << 53) - 64'd1);
    send_operand(1'b0, 12'sd1023, 64'd1);
    send_operand(1'b1, 12'sd1024, 64'd1);
    // Right shifts of the top bit: exact, lossy, and all bits gone
    send_operand(1'b0, 12'd0, 64'd1 << 63);
    send_operand(1'b1, 12'd0, {si2b64_pkg::SIG_W{1'b1}});
    send_operand(1'b0, -12'sd1137, 64'd1 << 63);
    send_operand(1'b1, -12'sd1137, {si2b64_pkg::SIG_W{1'b1}});
    send_operand(1'b0, -12'sd1138, 64'd1 << 63);
    send_operand(1'b1, 12'sd5, 64'h5555_5555_5555_5555);
    send_operand(1'b0, -12'sd20, 64'hAAAA_AAAA_AAAA_AAAA);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        send_mode = $urandom_range(IDLE_NONE, IDLE_SHORT);
      end
      // Pause once mid-run until the pipeline has emptied
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      case ($urandom_range(0, 9))
        0:       c = '0;
        1:       c = {si2b64_pkg::SIG_W{1'b1}};
        2:       c = 64'd1 << $urandom_range(0, 63);
        3, 4, 5: c = {$urandom, $urandom};
        default: begin
          wid  = $urandom_range(1, 64);
          mask = (wid == 64) ? {si2b64_pkg::SIG_W{1'b1}} : (64'd1 << wid) - 64'd1;
          c    = ({$urandom, $urandom} & mask) | (64'd1 << (wid - 1));
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: ev = $urandom_range(0, 4095) - 2048;
        3, 4:    ev = $urandom_range(0, 140) - 1140;
        5, 6:    ev = $urandom_range(0, 130) + 900;
        default: ev = $urandom_range(0, 200) - 100;
      endcase
      send_operand(1'($urandom_range(0, 1)), ev[si2b64_pkg::EXP_W-1:0], c);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, with two long hold-offs to back up the pipe
  initial begin
    int got;
    int hold;
    int rx_mode;
    out_stall <= 1'b0;
    got     = 0;
    rx_mode = IDLE_NONE;
    do @(posedge clk); while (rst);
    forever begin
      if (got % 40 == 0) begin
        rx_mode = $urandom_range(IDLE_NONE, IDLE_SHORT);
      end
      if (got == 300 || got == 1200) begin
        hold = 150;
      end else begin
        hold = draw_idle(rx_mode);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/si2b64_pkg.sv
rtl/scaled_integer_to_binary64_core.sv
test/binary64_pack_checker.sv
test/tb_scaled_integer_to_binary64_core.sv
